[rtl/dh_forward_kinematics_unit_assert.svh]
// Assertion macros for the DH forward kinematics unit
`ifndef DH_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset
`define DHFK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define DHFK_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/dhfk_pkg.sv]
// Shared types, constants and tables for the DH forward kinematics unit
package dhfk_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned AngW = 40;
  localparam int unsigned AccW = 66;

  localparam logic signed [AngW-1:0] Q30TwoPi  = 40'sd6746518852;
  localparam logic signed [AngW-1:0] Q30Pi     = 40'sd3373259426;
  localparam logic signed [AngW-1:0] Q30HalfPi = 40'sd1686629713;
  localparam logic signed [AngW-1:0] Q30Gain   = 40'sd652032874;
  localparam logic signed [ValW-1:0] Q24One    = 32'sd16777216;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_DELTA   = 2'd1,
    ACT_FULL    = 2'd2,
    ACT_PARTIAL = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CORD_TH_START,
    ST_CORD_TH_WAIT,
    ST_CORD_AL_START,
    ST_CORD_AL_WAIT,
    ST_LINK,
    ST_MAC,
    ST_NEXT,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic init_t;
    logic fetch;
    logic cord_start;
    logic cord_sel_al;
    logic link_step;
    logic link_first;
    logic mac_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cord_done;
    logic link_done;
    logic mac_done;
  } dp_sts_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 40'sd843314857;
      5'd1: atan_q30 = 40'sd497837829;
      5'd2: atan_q30 = 40'sd263043837;
      5'd3: atan_q30 = 40'sd133525159;
      5'd4: atan_q30 = 40'sd67021687;
      5'd5: atan_q30 = 40'sd33543516;
      5'd6: atan_q30 = 40'sd16775851;
      5'd7: atan_q30 = 40'sd8388437;
      5'd8: atan_q30 = 40'sd4194283;
      5'd9: atan_q30 = 40'sd2097149;
      default: atan_q30 = 40'sd1 <<< (5'd30 - i);
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] sat32(input logic signed [AccW-1:0] x);
    if (x > AccW'(64'sd2147483647)) sat32 = 32'sh7fffffff;
    else if (x < -AccW'(64'sd2147483648)) sat32 = 32'sh80000000;
    else sat32 = x[ValW-1:0];
  endfunction

endpackage

[rtl/dh_forward_kinematics_unit.sv]
// A load or delta item gives no result; a compute item runs all joints or the first
// PARTIAL_JOINTS through the one shared CORDIC and the one shared multiplier, then gives
// three row items. One item at a time; input is stalled until the last row is taken.
// Reset clears the angle deltas and control; table words are undefined until written.
module dh_forward_kinematics_unit
  import dhfk_pkg::*;
#(
  parameter int unsigned NUM_JOINTS     = 6,
  parameter int unsigned PARTIAL_JOINTS = 3,
  parameter int unsigned CORDIC_STEPS   = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [2:0]             joint_index_i,
  input  logic [1:0]             param_select_i,
  input  logic signed [31:0]     value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             row_index_o,
  output logic signed [31:0]     col0_o,
  output logic signed [31:0]     col1_o,
  output logic signed [31:0]     col2_o,
  output logic signed [31:0]     col3_o,
  output logic                   last_o
);

  localparam int unsigned JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned PartCnt =
    (PARTIAL_JOINTS < NUM_JOINTS) ? PARTIAL_JOINTS : NUM_JOINTS;

  `include "dh_forward_kinematics_unit_assert.svh"

  logic          accept, busy, jok;
  action_e       act;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [JW-1:0] joint;
  logic [JW:0]   count;

  assign act = action_e'(action_i);
  assign in_stall_o = busy;
  assign accept = in_valid_i && !busy;
  assign jok = 32'(joint_index_i) < NUM_JOINTS;
  assign count = (act == ACT_PARTIAL) ? (JW+1)'(PartCnt) : (JW+1)'(NUM_JOINTS);

  dhfk_ctrl #(.JW(JW)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i    (accept && (act == ACT_FULL || act == ACT_PARTIAL)),
    .count_i    (count),
    .sts_i      (sts),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .joint_o    (joint),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .row_o      (row_index_o)
  );

  dhfk_datapath #(
    .NumJoints(NUM_JOINTS), .CordicSteps(CORDIC_STEPS), .JW(JW)
  ) u_dp (
    .clk_i, .rst_ni,
    .wr_tbl_i  (accept && act == ACT_LOAD && jok),
    .wr_delta_i(accept && act == ACT_DELTA && jok),
    .wjoint_i  (joint_index_i),
    .wsel_i    (param_select_i),
    .wvalue_i  (value_i),
    .joint_i   (joint),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .row_i     (row_index_o),
    .col0_o, .col1_o, .col2_o, .col3_o
  );

  assign last_o = (row_index_o == 2'd2);

  // Results only appear while busy, rows never go past two
  `DHFK_ASSERT(a_out_busy, out_valid_o |-> busy, "result item while idle")
  `DHFK_ASSERT_NEVER(a_row_rng, out_valid_o && row_index_o == 2'd3, "row index out of range")
  `DHFK_ASSERT(a_no_accept_busy, busy |-> !accept, "item accepted while busy")

endmodule

[rtl/dhfk_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q10.24 angle in, Q8.24 out
module dhfk_cordic
  import dhfk_pkg::*;
#(
  parameter int unsigned CordicSteps = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [ValW+1:0] angle_i,
  output logic                   done_o,
  output logic signed [ValW-1:0] sin_o,
  output logic signed [ValW-1:0] cos_o
);

  localparam int unsigned PhW = 2;
  // Reciprocal of two pi in Q8.24 units, scaled by 2^40
  localparam logic signed [15:0] InvTwoPi = 16'sd10430;

  logic [PhW-1:0]          phase_q, phase_d;
  logic [4:0]              it_q, it_d;
  logic signed [AngW+1:0]  r_q, r_d;
  logic signed [AngW-1:0]  x_q, x_d, y_q, y_d;
  logic                    flip_q, flip_d;
  logic signed [8:0]       q_q, q_d;
  logic signed [AngW+1:0]  prod;
  logic signed [49:0]      qprod;
  logic signed [AngW-1:0]  xe, ye;

  assign prod = 42'(angle_i) <<< 6;
  // Whole turns in the angle, at most one short of the true count
  assign qprod = 50'(angle_i) * 50'(InvTwoPi);
  assign xe = flip_q ? -x_q : x_q;
  assign ye = flip_q ? -y_q : y_q;

  // Phase 0 idle, 3 remove whole turns, 1 reduce into [-pi, pi) and fold, 2 iterate
  always_comb begin
    phase_d = phase_q;
    it_d = it_q;
    r_d = r_q;
    x_d = x_q;
    y_d = y_q;
    flip_d = flip_q;
    q_d = q_q;
    done_o = 1'b0;
    case (phase_q)
      2'd0: begin
        if (start_i) begin
          r_d = prod;
          q_d = 9'(qprod >>> 40);
          phase_d = 2'd3;
        end
      end
      2'd3: begin
        r_d = r_q - 42'(q_q) * 42'(Q30TwoPi);
        phase_d = 2'd1;
      end
      2'd1: begin
        // Steps of two pi are taken off until the angle lies in [-pi, pi)
        if (r_q >= 42'(Q30Pi)) r_d = r_q - 42'(Q30TwoPi);
        else if (r_q < -42'(Q30Pi)) r_d = r_q + 42'(Q30TwoPi);
        else begin
          phase_d = 2'd2;
          it_d = '0;
          x_d = Q30Gain;
          y_d = '0;
          flip_d = 1'b0;
          if (r_q > 42'(Q30HalfPi)) begin
            r_d = r_q - 42'(Q30Pi);
            flip_d = 1'b1;
          end else if (r_q < -42'(Q30HalfPi)) begin
            r_d = r_q + 42'(Q30Pi);
            flip_d = 1'b1;
          end
        end
      end
      2'd2: begin
        if (it_q == 5'(CordicSteps)) begin
          done_o = 1'b1;
          phase_d = 2'd0;
        end else begin
          if (!r_q[AngW+1]) begin
            x_d = x_q - (y_q >>> it_q);
            y_d = y_q + (x_q >>> it_q);
            r_d = r_q - 42'(atan_q30(it_q));
          end else begin
            x_d = x_q + (y_q >>> it_q);
            y_d = y_q - (x_q >>> it_q);
            r_d = r_q + 42'(atan_q30(it_q));
          end
          it_d = it_q + 5'd1;
        end
      end
    endcase
  end

  logic signed [AngW-1:0] cr, sr;
  assign cr = (xe + 40'sd32) >>> 6;
  assign sr = (ye + 40'sd32) >>> 6;
  assign cos_o = cr[ValW-1:0];
  assign sin_o = sr[ValW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    flip_q <= flip_d;
    q_q <= q_d;
  end

endmodule

[rtl/dhfk_datapath.sv]
// Datapath: parameter stores, CORDIC, link matrix build and matrix multiply
module dhfk_datapath
  import dhfk_pkg::*;
#(
  parameter int unsigned NumJoints   = 6,
  parameter int unsigned CordicSteps = 24,
  parameter int unsigned JW          = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_tbl_i,
  input  logic                   wr_delta_i,
  input  logic [2:0]             wjoint_i,
  input  logic [1:0]             wsel_i,
  input  logic signed [ValW-1:0] wvalue_i,
  input  logic [JW-1:0]          joint_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic [1:0]             row_i,
  output logic signed [ValW-1:0] col0_o,
  output logic signed [ValW-1:0] col1_o,
  output logic signed [ValW-1:0] col2_o,
  output logic signed [ValW-1:0] col3_o
);

  localparam int unsigned TblWords = NumJoints * 4;
  localparam int unsigned TAW = $clog2(TblWords);
  // Link entries a*cos and a*sin can reach just past the 32-bit range
  localparam int unsigned LkW = ValW + 2;

  // Parameter table memory, one read port
  logic signed [ValW-1:0] tbl_mem [TblWords];
  logic signed [ValW-1:0] delta_q [NumJoints];
  logic [1:0]             rd_cnt_q;
  logic                   rd_act_q;
  logic signed [ValW-1:0] rd_data_q;
  logic signed [ValW-1:0] a_q, al_q, d_q, off_q;
  logic signed [ValW-1:0] dl_q;

  always_ff @(posedge clk_i) begin
    if (wr_tbl_i) tbl_mem[TAW'({wjoint_i, wsel_i})] <= wvalue_i;
    rd_data_q <= tbl_mem[TAW'({joint_i, rd_cnt_q})];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumJoints; j++) delta_q[j] <= '0;
    end else if (wr_delta_i) begin
      delta_q[JW'(wjoint_i)] <= wvalue_i;
    end
  end

  // Fetch: read the four words of the joint one after another
  logic [1:0] cap_idx_q;
  logic       cap_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_act_q <= 1'b0;
      cap_v_q <= 1'b0;
      cap_idx_q <= '0;
    end else begin
      cap_v_q <= rd_act_q;
      cap_idx_q <= rd_cnt_q;
      if (cmd_i.fetch) begin
        rd_act_q <= 1'b1;
        rd_cnt_q <= '0;
      end else if (rd_act_q) begin
        if (rd_cnt_q == 2'd3) rd_act_q <= 1'b0;
        else rd_cnt_q <= rd_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_v_q) begin
      case (cap_idx_q)
        2'd0: a_q <= rd_data_q;
        2'd1: al_q <= rd_data_q;
        2'd2: d_q <= rd_data_q;
        default: off_q <= rd_data_q;
      endcase
    end
    if (cmd_i.fetch) dl_q <= delta_q[joint_i];
  end

  // CORDIC shared by theta and alpha
  logic signed [ValW+1:0] cang;
  logic signed [ValW-1:0] csin, ccos;
  logic                   cdone;
  assign cang = cmd_i.cord_sel_al ? 34'(al_q) : (34'(off_q) + 34'(dl_q));

  dhfk_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni,
    .start_i(cmd_i.cord_start),
    .angle_i(cang),
    .done_o (cdone),
    .sin_o  (csin),
    .cos_o  (ccos)
  );

  logic signed [ValW-1:0] st_q, ct_q, sa_q, ca_q;
  always_ff @(posedge clk_i) begin
    if (cdone && !cmd_i.cord_sel_al) begin
      st_q <= csin;
      ct_q <= ccos;
    end
    if (cdone && cmd_i.cord_sel_al) begin
      sa_q <= csin;
      ca_q <= ccos;
    end
  end

  // Shared 32x34 multiplier, registered product
  logic signed [ValW-1:0]   ma;
  logic signed [LkW-1:0]    mb;
  logic signed [AccW-1:0]   mp_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [LkW-1:0]    lk_q [3][4];
  logic signed [ValW-1:0]   t_q  [3][4];
  logic signed [ValW-1:0]   nt_q [3][4];

  // Link build sequencer: six products, one per cycle, each written back from the product register
  logic [2:0] lstep_q;
  logic [2:0] lstep_p_q;
  logic       lvalid_q;
  // Multiply sequencer over 12 entries by 3 terms
  logic [1:0] mr_q, mk_q, mm_q;
  logic [1:0] pr_q, pk_q, pm_q;
  logic       pv_q;
  logic       mac_busy;

  assign mac_busy = cmd_i.mac_step;

  always_comb begin
    ma = '0;
    mb = '0;
    if (mac_busy) begin
      ma = t_q[mr_q][mm_q];
      mb = lk_q[mm_q][mk_q];
    end else begin
      case (lstep_q)
        3'd0: begin ma = st_q; mb = LkW'(ca_q); end
        3'd1: begin ma = st_q; mb = LkW'(sa_q); end
        3'd2: begin ma = a_q;  mb = LkW'(ct_q); end
        3'd3: begin ma = ct_q; mb = LkW'(ca_q); end
        3'd4: begin ma = ct_q; mb = LkW'(sa_q); end
        default: begin ma = a_q; mb = LkW'(st_q); end
      endcase
    end
  end

  logic signed [AccW-1:0] qr;
  logic signed [LkW-1:0]  qv;
  assign qr = (mp_q + AccW'(64'sd8388608)) >>> 24;
  assign qv = qr[LkW-1:0];

  logic signed [AccW-1:0] acc_n;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] fin;
  assign acc_n = (pm_q == 2'd0) ? mp_q : acc_q + mp_q;
  assign rnd = (acc_n + AccW'(64'sd8388608)) >>> 24;
  assign fin = (pk_q == 2'd3) ? rnd + AccW'(t_q[pr_q][3]) : rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstep_q <= '0;
      lvalid_q <= 1'b0;
      lstep_p_q <= '0;
      mr_q <= '0;
      mk_q <= '0;
      mm_q <= '0;
      pv_q <= 1'b0;
      pr_q <= '0;
      pk_q <= '0;
      pm_q <= '0;
    end else begin
      lvalid_q <= cmd_i.link_step && !cmd_i.link_first && lstep_q != 3'd6;
      lstep_p_q <= lstep_q;
      if (cmd_i.link_first) lstep_q <= '0;
      else if (cmd_i.link_step && lstep_q != 3'd6) lstep_q <= lstep_q + 3'd1;
      pv_q <= mac_busy && !(mr_q == 2'd3);
      pr_q <= mr_q;
      pk_q <= mk_q;
      pm_q <= mm_q;
      if (!mac_busy) begin
        mr_q <= '0;
        mk_q <= '0;
        mm_q <= '0;
      end else if (mr_q != 2'd3) begin
        if (mm_q == 2'd2) begin
          mm_q <= '0;
          if (mk_q == 2'd3) begin
            mk_q <= '0;
            mr_q <= mr_q + 2'd1;
          end else begin
            mk_q <= mk_q + 2'd1;
          end
        end else begin
          mm_q <= mm_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q <= AccW'(ma) * AccW'(mb);
    if (pv_q) acc_q <= acc_n;
    if (pv_q && pm_q == 2'd2) nt_q[pr_q][pk_q] <= sat32(fin);
    if (cmd_i.link_first) begin
      lk_q[0][0] <= LkW'(ct_q);
      lk_q[1][0] <= LkW'(st_q);
      lk_q[2][0] <= '0;
      lk_q[2][1] <= LkW'(sa_q);
      lk_q[2][2] <= LkW'(ca_q);
      lk_q[2][3] <= LkW'(d_q);
    end
    if (lvalid_q) begin
      case (lstep_p_q)
        3'd0: lk_q[0][1] <= -qv;
        3'd1: lk_q[0][2] <= qv;
        3'd2: lk_q[0][3] <= qv;
        3'd3: lk_q[1][1] <= qv;
        3'd4: lk_q[1][2] <= -qv;
        default: lk_q[1][3] <= qv;
      endcase
    end
    if (cmd_i.init_t) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 4; k++)
          t_q[r][k] <= (r == k) ? Q24One : '0;
    end else if (cmd_i.out_load) begin
      t_q <= nt_q;
    end
  end

  assign sts_o.cord_done = cdone;
  assign sts_o.link_done = (lstep_q == 3'd6) && !lvalid_q;
  assign sts_o.mac_done  = (mr_q == 2'd3) && !pv_q;

  assign col0_o = t_q[row_i][0];
  assign col1_o = t_q[row_i][1];
  assign col2_o = t_q[row_i][2];
  assign col3_o = t_q[row_i][3];

endmodule

[rtl/dhfk_ctrl.sv]
// Controller: sequences fetch, CORDIC, link build, multiply and row output
module dhfk_ctrl
  import dhfk_pkg::*;
#(
  parameter int unsigned JW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [JW:0]   count_i,
  input  dp_sts_t       sts_i,
  input  logic          out_stall_i,
  output dp_cmd_t       cmd_o,
  output logic [JW-1:0] joint_o,
  output logic          busy_o,
  output logic          out_valid_o,
  output logic [1:0]    row_o
);

  state_e      state_q, state_d;
  logic [JW:0] joint_q, joint_d;
  logic [JW:0] count_q, count_d;
  logic [1:0]  row_q, row_d;
  logic [2:0]  wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      joint_q <= '0;
      count_q <= '0;
      row_q <= '0;
      wait_q <= '0;
    end else begin
      state_q <= state_d;
      joint_q <= joint_d;
      count_q <= count_d;
      row_q <= row_d;
      wait_q <= wait_d;
    end
  end

  always_comb begin
    state_d = state_q;
    joint_d = joint_q;
    count_d = count_q;
    row_d = row_q;
    wait_d = wait_q;
    cmd_o = '0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.init_t = 1'b1;
          joint_d = '0;
          count_d = count_i;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // The wait covers the four reads and the read and capture registers
        if (joint_q == count_q) begin
          row_d = '0;
          state_d = ST_OUT;
        end else begin
          cmd_o.fetch = 1'b1;
          wait_d = '0;
          state_d = ST_CORD_TH_START;
        end
      end
      ST_CORD_TH_START: begin
        if (wait_q == 3'd6) begin
          cmd_o.cord_start = 1'b1;
          state_d = ST_CORD_TH_WAIT;
        end else begin
          wait_d = wait_q + 3'd1;
        end
      end
      ST_CORD_TH_WAIT: begin
        if (sts_i.cord_done) state_d = ST_CORD_AL_START;
      end
      ST_CORD_AL_START: begin
        cmd_o.cord_sel_al = 1'b1;
        cmd_o.cord_start = 1'b1;
        state_d = ST_CORD_AL_WAIT;
      end
      ST_CORD_AL_WAIT: begin
        cmd_o.cord_sel_al = 1'b1;
        if (sts_i.cord_done) begin
          state_d = ST_LINK;
          wait_d = '0;
        end
      end
      ST_LINK: begin
        cmd_o.link_step = 1'b1;
        cmd_o.link_first = (wait_q == 3'd0);
        wait_d = 3'd1;
        if (wait_q != 3'd0 && sts_i.link_done) state_d = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_done) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.out_load = 1'b1;
        joint_d = joint_q + 1'b1;
        state_d = ST_FETCH;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (row_q == 2'd2) state_d = ST_IDLE;
          row_d = row_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign joint_o = joint_q[JW-1:0];
  assign busy_o  = (state_q != ST_IDLE);
  assign row_o   = row_q;

endmodule

[sim/dh_forward_kinematics_checker.sv]
// Checker for the DH forward kinematics unit: predicts transform rows and compares them
module dh_forward_kinematics_checker
  import dhfk_pkg::*;
#(
  parameter int unsigned NUM_JOINTS     = 6,
  parameter int unsigned PARTIAL_JOINTS = 3,
  parameter int unsigned CORDIC_STEPS   = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         action_i,
  input  logic [2:0]         joint_index_i,
  input  logic [1:0]         param_select_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         row_index_i,
  input  logic signed [31:0] col0_i,
  input  logic signed [31:0] col1_i,
  input  logic signed [31:0] col2_i,
  input  logic signed [31:0] col3_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               last;
  } row_t;

  longint dh_words[NUM_JOINTS*4];
  longint joint_deltas[NUM_JOINTS];
  row_t   row_queue[$];
  int     err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = row_queue.size();

  function automatic longint asr64(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint arctan_step(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // rotation-mode CORDIC on a Q8.24 angle, sin and cos out in Q8.24
  task automatic sincos(input longint ang, output longint s, output longint c);
    longint tp, r, x, y, nx;
    bit     flip;
    tp = 64'sd6746518852;
    r = (ang * 64) % tp;
    x = 652032874;
    y = 0;
    flip = 0;
    if (r < 0) r += tp;
    if (r >= 64'sd3373259426) r -= tp;
    if (r > 64'sd1686629713) begin
      r -= 64'sd3373259426;
      flip = 1;
    end else if (r < -64'sd1686629713) begin
      r += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 62; i++) begin
      if (r >= 0) begin
        nx = x - asr64(y, i);
        y = y + asr64(x, i);
        r -= arctan_step(i);
      end else begin
        nx = x + asr64(y, i);
        y = y - asr64(x, i);
        r += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = asr64(x + 32, 6);
    s = asr64(y + 32, 6);
  endtask

  function automatic longint qmul(longint a, longint b);
    return asr64(a * b + 64'sd8388608, 24);
  endfunction

  // chain the link transforms and queue the three rows
  task automatic predict_transform(input int count);
    longint t[3][4], lk[3][4], nt[3][4];
    longint ct, st, ca, sa, acc, a;
    row_t   rw;
    foreach (t[r, k]) t[r][k] = 0;
    t[0][0] = 1 << 24;
    t[1][1] = 1 << 24;
    t[2][2] = 1 << 24;
    for (int j = 0; j < count; j++) begin
      a = dh_words[j*4];
      sincos(dh_words[j*4+3] + joint_deltas[j], st, ct);
      sincos(dh_words[j*4+1], sa, ca);
      lk[0][0] = ct; lk[0][1] = -qmul(st, ca); lk[0][2] = qmul(st, sa);
      lk[0][3] = qmul(a, ct);
      lk[1][0] = st; lk[1][1] = qmul(ct, ca); lk[1][2] = -qmul(ct, sa);
      lk[1][3] = qmul(a, st);
      lk[2][0] = 0; lk[2][1] = sa; lk[2][2] = ca; lk[2][3] = dh_words[j*4+2];
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 4; k++) begin
          acc = 0;
          for (int m = 0; m < 3; m++) acc += t[r][m] * lk[m][k];
          acc = asr64(acc + 64'sd8388608, 24);
          if (k == 3) acc += t[r][3];
          nt[r][k] = clamp32(acc);
        end
      end
      t = nt;
    end
    for (int r = 0; r < 3; r++) begin
      rw.row  = 2'(r);
      rw.c0   = 32'(t[r][0]);
      rw.c1   = 32'(t[r][1]);
      rw.c2   = 32'(t[r][2]);
      rw.c3   = 32'(t[r][3]);
      rw.last = (r == 2);
      row_queue.push_back(rw);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    row_t exp_row;
    int   cnt;
    if (!rst_ni) begin
      foreach (dh_words[i]) dh_words[i] = 0;
      foreach (joint_deltas[i]) joint_deltas[i] = 0;
      row_queue.delete();
      err_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (row_queue.size() == 0) begin
          report_mismatch("row item with nothing expected");
        end else begin
          exp_row = row_queue.pop_front();
          if (row_index_i !== exp_row.row)
            report_mismatch($sformatf("row_index %0d exp %0d", row_index_i, exp_row.row));
          if (col0_i !== exp_row.c0)
            report_mismatch($sformatf("row %0d col0 %0d exp %0d", exp_row.row, col0_i,
                                      exp_row.c0));
          if (col1_i !== exp_row.c1)
            report_mismatch($sformatf("row %0d col1 %0d exp %0d", exp_row.row, col1_i,
                                      exp_row.c1));
          if (col2_i !== exp_row.c2)
            report_mismatch($sformatf("row %0d col2 %0d exp %0d", exp_row.row, col2_i,
                                      exp_row.c2));
          if (col3_i !== exp_row.c3)
            report_mismatch($sformatf("row %0d col3 %0d exp %0d", exp_row.row, col3_i,
                                      exp_row.c3));
          if (last_i !== exp_row.last)
            report_mismatch($sformatf("row %0d last %0b", exp_row.row, last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (action_e'(action_i))
          ACT_LOAD: begin
            if (joint_index_i < NUM_JOINTS)
              dh_words[joint_index_i*4 + param_select_i] = longint'(value_i);
          end
          ACT_DELTA: begin
            if (joint_index_i < NUM_JOINTS) joint_deltas[joint_index_i] = longint'(value_i);
          end
          ACT_FULL: predict_transform(NUM_JOINTS);
          default: begin
            cnt = (PARTIAL_JOINTS < NUM_JOINTS) ? PARTIAL_JOINTS : NUM_JOINTS;
            predict_transform(cnt);
          end
        endcase
      end
    end
  end

endmodule

[sim/testbench.sv]
// Testbench top for the DH forward kinematics unit: stimulus, idling phases and verdict
module testbench;
  import dhfk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         action_i = ACT_LOAD;
  logic [2:0]         joint_index_i = 0;
  logic [1:0]         param_select_i = 0;
  logic signed [31:0] value_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [1:0]         row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;
  logic               last_o;
  int                 errors, pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  dh_forward_kinematics_unit dut (.*);

  dh_forward_kinematics_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .joint_index_i,
    .param_select_i, .value_i, .out_valid_i(out_valid_o), .out_stall_i, .row_index_i(row_index_o),
    .col0_i(col0_o), .col1_i(col1_o), .col2_i(col2_o), .col3_i(col3_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // present one item, idle first at random, hold until accepted; valid stays high after
  task automatic send_item(input action_e act, input int jnt, input int sel,
                           input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    joint_index_i  <= 3'(jnt);
    param_select_i <= 2'(sel);
    value_i        <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // angles mostly moderate, sometimes any 32-bit value
  function automatic logic [31:0] rand_angle();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * 120000000)) - 120000000);
  endfunction

  // lengths mostly near a metre, sometimes huge to reach saturation
  function automatic logic [31:0] rand_length();
    if ($urandom_range(4) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * 40000000)) - 40000000);
  endfunction

  task automatic load_table_random();
    for (int j = 0; j < 6; j++) begin
      send_item(ACT_LOAD, j, 0, rand_length());
      send_item(ACT_LOAD, j, 1, rand_angle());
      send_item(ACT_LOAD, j, 2, rand_length());
      send_item(ACT_LOAD, j, 3, rand_angle());
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int n);
    int r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_item(ACT_LOAD, $urandom_range(7), $urandom_range(3),
                            ($urandom_range(1) != 0) ? rand_angle() : rand_length());
      else if (r < 65) send_item(ACT_DELTA, $urandom_range(7), $urandom_range(3), rand_angle());
      else if (r < 85) send_item(ACT_FULL, $urandom_range(7), $urandom_range(3), $urandom);
      else send_item(ACT_PARTIAL, $urandom_range(7), $urandom_range(3), $urandom);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero table, extremes, both chains, ignored joints
    for (int j = 0; j < 6; j++)
      for (int p = 0; p < 4; p++) send_item(ACT_LOAD, j, p, 32'd0);
    send_item(ACT_FULL, 0, 0, 32'd0);
    send_item(ACT_LOAD, 0, 0, 32'h7fffffff);
    send_item(ACT_LOAD, 1, 0, 32'h7fffffff);
    send_item(ACT_LOAD, 2, 2, 32'h80000000);
    send_item(ACT_LOAD, 0, 3, 32'h80000000);
    send_item(ACT_LOAD, 1, 1, 32'h7fffffff);
    send_item(ACT_DELTA, 5, 3, 32'h7fffffff);
    send_item(ACT_DELTA, 2, 0, 32'h3243f6a);
    send_item(ACT_LOAD, 6, 3, 32'h12345678);
    send_item(ACT_DELTA, 7, 0, 32'h00ffffff);
    send_item(ACT_FULL, 7, 3, 32'hffffffff);
    send_item(ACT_PARTIAL, 0, 0, 32'h0);
    send_item(ACT_DELTA, 2, 0, 32'h80000000);
    send_item(ACT_PARTIAL, 0, 0, 32'h0);

    load_table_random();
    random_phase(0, 0, 40);
    random_phase(66, 0, 40);
    random_phase(0, 66, 40);
    load_table_random();
    random_phase(6, 6, 40);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule
